// ----- hw/rtl/m640_pkg.sv -----
package m640_pkg;

  // input operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  localparam int unsigned NumWords = 5;
  localparam int unsigned WordW    = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned LaneW    = 32;
  localparam int unsigned IdxW     = 3;

  // per-row lane rotation amounts
  localparam int unsigned RotRow0 = 5;
  localparam int unsigned RotRow1 = 31;
  localparam int unsigned RotRow2 = 7;
  localparam int unsigned RotRow3 = 22;
  localparam int unsigned RotRow4 = 13;

  typedef enum logic [0:0] {
    KIND_LOAD,
    KIND_ENCRYPT
  } kind_e;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] idx;
    word_t           data;
  } cmd_t;

  // rotate every 32-bit lane left by n, 1 <= n <= 31
  function automatic word_t lane_rotl(input word_t w, input int unsigned n);
    word_t            r;
    logic [LaneW-1:0] x;
    for (int i = 0; i < 4; i++) begin
      x = w[i*LaneW +: LaneW];
      r[i*LaneW +: LaneW] = (x << n) | (x >> (LaneW - n));
    end
    return r;
  endfunction

  // rotate the whole word left by k lanes, 1 <= k <= 3
  function automatic word_t word_rotl(input word_t w, input int unsigned k);
    return (w << (k * LaneW)) | (w >> (WordW - k * LaneW));
  endfunction

endpackage

// ----- hw/rtl/m640_in_if.sv -----
interface m640_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  word_index;
  logic [63:0] data_hi;
  logic [63:0] data_lo;

  modport source (output valid, operation, word_index, data_hi, data_lo, input ready);
  modport sink   (input valid, operation, word_index, data_hi, data_lo, output ready);
endinterface

// ----- hw/rtl/m640_out_if.sv -----
interface m640_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  logic [63:0] word0_hi;
  logic [63:0] word0_lo;
  logic [63:0] word1_hi;
  logic [63:0] word1_lo;
  logic [63:0] word2_hi;
  logic [63:0] word2_lo;
  logic [63:0] word3_hi;
  logic [63:0] word3_lo;
  logic [63:0] word4_hi;
  logic [63:0] word4_lo;

  modport source (
    output valid, cipher_hi, cipher_lo, word0_hi, word0_lo, word1_hi, word1_lo,
           word2_hi, word2_lo, word3_hi, word3_lo, word4_hi, word4_lo,
    input  ready
  );
  modport sink (
    input  valid, cipher_hi, cipher_lo, word0_hi, word0_lo, word1_hi, word1_lo,
           word2_hi, word2_lo, word3_hi, word3_lo, word4_hi, word4_lo,
    output ready
  );
endinterface

// ----- hw/rtl/m640_front.sv -----
module m640_front (
  m640_in_if.sink        in_i,
  input  logic           full_i,
  output logic           push_o,
  output m640_pkg::cmd_t cmd_o
);

  logic drop;

  // loads aimed past the last word are taken and discarded
  assign drop = (in_i.operation == m640_pkg::OP_LOAD) &&
                (in_i.word_index >= m640_pkg::IdxW'(m640_pkg::NumWords));

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && !drop;

  always_comb begin
    cmd_o.kind = (in_i.operation == m640_pkg::OP_ENCRYPT) ? m640_pkg::KIND_ENCRYPT
                                                          : m640_pkg::KIND_LOAD;
    cmd_o.idx  = in_i.word_index;
    cmd_o.data = {in_i.data_hi, in_i.data_lo};
  end

endmodule

// ----- hw/rtl/m640_queue.sv -----
module m640_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  m640_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output m640_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  m640_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/m640_back.sv -----
module m640_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  m640_pkg::cmd_t cmd_i,
  output logic           pop_o,
  m640_out_if.source     out_o
);

  logic [m640_pkg::NumWords-1:0][m640_pkg::WordW-1:0] state_q, state_d;
  logic [m640_pkg::NumWords-1:0][m640_pkg::WordW-1:0] upd;
  logic [m640_pkg::NumWords-1:0][m640_pkg::WordW-1:0] words_q;
  m640_pkg::word_t cipher_q, ks, m;
  m640_pkg::word_t t0, t1, t2, t3, t4, s3r, s4r, t0r, t1r;
  logic            out_valid_q, out_valid_d;
  logic            is_enc, pop_enc, pop_load, out_fire;

  assign is_enc   = (cmd_i.kind == m640_pkg::KIND_ENCRYPT);
  assign out_fire = out_valid_q && out_o.ready;
  // loads never wait on the output side
  assign pop_o    = cmd_valid_i && (!is_enc || !out_valid_q || out_o.ready);
  assign pop_enc  = pop_o && is_enc;
  assign pop_load = pop_o && !is_enc;
  assign m        = cmd_i.data;

  // keystream and five-row update
  always_comb begin
    ks  = state_q[0] ^ m640_pkg::word_rotl(state_q[1], 3) ^ (state_q[2] & state_q[3]) ^ m;
    t0  = m640_pkg::lane_rotl(state_q[0] ^ state_q[3] ^ (state_q[1] & state_q[2]),
                              m640_pkg::RotRow0);
    s3r = m640_pkg::word_rotl(state_q[3], 1);
    t1  = m640_pkg::lane_rotl(state_q[1] ^ m ^ state_q[4] ^ (state_q[2] & s3r),
                              m640_pkg::RotRow1);
    s4r = m640_pkg::word_rotl(state_q[4], 2);
    t2  = m640_pkg::lane_rotl(state_q[2] ^ m ^ t0 ^ (s3r & s4r), m640_pkg::RotRow2);
    t0r = m640_pkg::word_rotl(t0, 3);
    t3  = m640_pkg::lane_rotl(s3r ^ m ^ t1 ^ (s4r & t0r), m640_pkg::RotRow3);
    t1r = m640_pkg::word_rotl(t1, 2);
    t4  = m640_pkg::lane_rotl(s4r ^ m ^ t2 ^ (t0r & t1r), m640_pkg::RotRow4);
    upd[0] = t0r;
    upd[1] = t1r;
    upd[2] = m640_pkg::word_rotl(t2, 1);
    upd[3] = t3;
    upd[4] = t4;
  end

  always_comb begin
    state_d = state_q;
    if (pop_enc) begin
      state_d = upd;
    end else if (pop_load) begin
      state_d[cmd_i.idx] = cmd_i.data;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_enc) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_enc) begin
      cipher_q <= ks;
      words_q  <= upd;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cipher_hi = cipher_q[127:64];
  assign out_o.cipher_lo = cipher_q[63:0];
  assign out_o.word0_hi  = words_q[0][127:64];
  assign out_o.word0_lo  = words_q[0][63:0];
  assign out_o.word1_hi  = words_q[1][127:64];
  assign out_o.word1_lo  = words_q[1][63:0];
  assign out_o.word2_hi  = words_q[2][127:64];
  assign out_o.word2_lo  = words_q[2][63:0];
  assign out_o.word3_hi  = words_q[3][127:64];
  assign out_o.word3_lo  = words_q[3][63:0];
  assign out_o.word4_hi  = words_q[4][127:64];
  assign out_o.word4_lo  = words_q[4][63:0];

`ifndef SYNTH
  a_enc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_enc |=> out_valid_q)
    else $error("encrypt beat did not produce a result");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_load && !out_valid_q) |=> !out_valid_q)
    else $error("load beat produced a result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(state_q))
    else $error("state changed without a command");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_enc |=> (words_q == state_q))
    else $error("reported words differ from stored state");
`endif

endmodule

// ----- hw/rtl/morus640_encrypt_step.sv -----
// morus-640 encryption step: holds the 640-bit state as five 128-bit words.
// a load beat (operation 0) writes word word_index with {data_hi, data_lo}
// and returns nothing; loads with word_index above 4 are taken and dropped.
// an encrypt beat (operation 1) takes a plaintext block {data_hi, data_lo},
// returns the ciphertext p ^ s0 ^ (s1 <<< 96) ^ (s2 & s3) and the five words
// after the state update, and keeps the updated state. the state is all zero
// after reset. one beat is accepted every cycle while the command queue has
// room. a result passes through the command queue and the output register: the
// beat is written into the command queue when it is accepted, and the update
// stage pops it and writes the output register when that register holds no
// result or its result is being taken. the whole five-row update is done
// combinationally in the back end, so the state loop sets the rate. the queue
// between the front end and the back end lets the input keep flowing while a
// result waits at the output, until the queue holds QueueDepth beats
module morus640_encrypt_step #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  m640_in_if.sink    in_i,
  m640_out_if.source out_o
);

  // front end to queue
  m640_pkg::cmd_t front_cmd;
  logic           front_push;
  logic           queue_full;

  // queue to back end
  m640_pkg::cmd_t head_cmd;
  logic           head_valid;
  logic           head_pop;

  // decode and filter incoming beats
  m640_front u_front (
    .in_i   (in_i),
    .full_i (queue_full),
    .push_o (front_push),
    .cmd_o  (front_cmd)
  );

  // short command queue decoupling input from the state update
  m640_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // state words, keystream, update and output register
  m640_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (head_pop),
    .out_o       (out_o)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import m640_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned RandomBeats = 2000;
  localparam int unsigned PhaseCount  = 4;
  // watch window for stray results once all expected ones have arrived
  localparam int unsigned DrainCycles = 12;
  // far beyond the slowest legal run (50% idle or 50% stall on every beat in a phase)
  localparam int unsigned CycleLimit  = 200000;

  // one result beat packed as halves: cipher hi/lo, then word0 hi/lo .. word4 hi/lo
  typedef logic [11:0][HalfW-1:0] block_out_t;

  // tracks the morus state, predicts each encrypt result and checks the output
  class morus_tracker;
    word_t      state_w[NumWords];
    block_out_t expected_blocks[$];
    int         errors;

    function new();
      foreach (state_w[i]) state_w[i] = '0;
      errors = 0;
    endfunction

    // each 32-bit lane rotated left by n
    function word_t lane_rot(word_t w, int unsigned n);
      word_t       r;
      logic [63:0] dbl;
      for (int i = 0; i < 4; i++) begin
        dbl = {w[i*LaneW +: LaneW], w[i*LaneW +: LaneW]};
        r[i*LaneW +: LaneW] = dbl[63-n -: 32];
      end
      return r;
    endfunction

    // whole word rotated left by k lanes
    function word_t word_rot(word_t w, int unsigned k);
      logic [2*WordW-1:0] dbl;
      dbl = {w, w};
      return dbl[2*WordW-1-k*LaneW -: WordW];
    endfunction

    // ciphertext of block m, then the five-row state update
    function block_out_t encrypt_block(word_t m);
      block_out_t res;
      word_t      s0, s1, s2, s3, s4, ks;
      s0 = state_w[0];
      s1 = state_w[1];
      s2 = state_w[2];
      s3 = state_w[3];
      s4 = state_w[4];
      ks = m ^ s0 ^ word_rot(s1, 3) ^ (s2 & s3);

      s0 = lane_rot(s0 ^ s3 ^ (s1 & s2), RotRow0);
      s3 = word_rot(s3, 1);
      s1 = lane_rot(s1 ^ m ^ s4 ^ (s2 & s3), RotRow1);
      s4 = word_rot(s4, 2);
      s2 = lane_rot(s2 ^ m ^ s0 ^ (s3 & s4), RotRow2);
      s0 = word_rot(s0, 3);
      s3 = lane_rot(s3 ^ m ^ s1 ^ (s4 & s0), RotRow3);
      s1 = word_rot(s1, 2);
      s4 = lane_rot(s4 ^ m ^ s2 ^ (s0 & s1), RotRow4);
      s2 = word_rot(s2, 1);

      state_w[0] = s0;
      state_w[1] = s1;
      state_w[2] = s2;
      state_w[3] = s3;
      state_w[4] = s4;
      res[0] = ks[127:64];
      res[1] = ks[63:0];
      for (int k = 0; k < NumWords; k++) begin
        res[2+2*k] = state_w[k][127:64];
        res[3+2*k] = state_w[k][63:0];
      end
      return res;
    endfunction

    function void note_beat(logic op, logic [IdxW-1:0] idx, logic [HalfW-1:0] hi,
                            logic [HalfW-1:0] lo);
      if (op == OP_LOAD) begin
        if (idx < NumWords) state_w[idx] = {hi, lo};
      end else begin
        expected_blocks.push_back(encrypt_block({hi, lo}));
      end
    endfunction

    function string half_name(int i);
      if (i == 0) return "cipher_hi";
      if (i == 1) return "cipher_lo";
      return $sformatf("word%0d_%s", (i - 2) / 2, (i % 2) ? "lo" : "hi");
    endfunction

    function void check_block(block_out_t got);
      block_out_t want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got cipher %h_%h",
                 $time, got[0], got[1]);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: %s expected %h got %h", $time, half_name(i), want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function void flush_check();
      block_out_t want;
      while (expected_blocks.size() != 0) begin
        want = expected_blocks.pop_front();
        $display("%0t: missing result, expected cipher %h_%h got none",
                 $time, want[0], want[1]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   cycle_count;

  morus_tracker tracker;

  m640_in_if  in_bus();
  m640_out_if out_bus();

  morus640_encrypt_step uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // cycle counter for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  // receiver: ready drops at random per the current stall rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: sample both handshakes at the edge, before any new drive lands
  always @(posedge clk) begin
    block_out_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        tracker.note_beat(in_bus.operation, in_bus.word_index, in_bus.data_hi,
                          in_bus.data_lo);
      end
      if (out_bus.valid && out_bus.ready) begin
        got[0]  = out_bus.cipher_hi;
        got[1]  = out_bus.cipher_lo;
        got[2]  = out_bus.word0_hi;
        got[3]  = out_bus.word0_lo;
        got[4]  = out_bus.word1_hi;
        got[5]  = out_bus.word1_lo;
        got[6]  = out_bus.word2_hi;
        got[7]  = out_bus.word2_lo;
        got[8]  = out_bus.word3_hi;
        got[9]  = out_bus.word3_lo;
        got[10] = out_bus.word4_hi;
        got[11] = out_bus.word4_lo;
        tracker.check_block(got);
      end
    end
  end

  // present one beat, with random idle cycles ahead of it, and hold it until taken.
  // called at a rising edge; returns at the edge where the beat was accepted
  task automatic send_beat(input logic op, input logic [IdxW-1:0] idx,
                           input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.word_index <= idx;
    in_bus.data_hi    <= hi;
    in_bus.data_lo    <= lo;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // mostly random halves, with the two extremes now and then
  function automatic logic [HalfW-1:0] pick_half();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      send_beat(OP_LOAD, IdxW'($urandom_range(NumWords - 1)), pick_half(), pick_half());
    end else if (r < 34) begin
      // out-of-range loads are dropped by the block
      send_beat(OP_LOAD, IdxW'($urandom_range(7, NumWords)), pick_half(), pick_half());
    end else begin
      send_beat(OP_ENCRYPT, IdxW'($urandom_range(7)), pick_half(), pick_half());
    end
  endtask

  task automatic run_directed();
    // encrypt on the all-zero reset state, then with all ones and a stray index
    send_beat(OP_ENCRYPT, 3'd0, '0, '0);
    send_beat(OP_ENCRYPT, 3'd7, '1, '1);
    // every word set to all ones
    for (int k = 0; k < NumWords; k++) send_beat(OP_LOAD, IdxW'(k), '1, '1);
    send_beat(OP_ENCRYPT, 3'd0, '0, '0);
    // loads past the last word must leave the state alone
    send_beat(OP_LOAD, 3'd5, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_beat(OP_LOAD, 3'd6, '0, '0);
    send_beat(OP_LOAD, 3'd7, '1, '1);
    send_beat(OP_ENCRYPT, 3'd5, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    // alternating bit patterns so every lane rotation shows up
    for (int k = 0; k < NumWords; k++) begin
      send_beat(OP_LOAD, IdxW'(k), (k % 2) ? 64'haaaa_aaaa_aaaa_aaaa : 64'h5555_5555_5555_5555,
                64'h8000_0001_0000_0001);
    end
    send_beat(OP_ENCRYPT, 3'd6, '1, '1);
    // one word cleared mid-stream, then back-to-back encrypts
    send_beat(OP_LOAD, 3'd2, '0, '0);
    send_beat(OP_ENCRYPT, 3'd1, '0, 64'h0000_0000_0000_0001);
    send_beat(OP_ENCRYPT, 3'd4, 64'h8000_0000_0000_0000, '0);
    send_beat(OP_ENCRYPT, 3'd2, '1, '0);
  endtask

  initial begin
    tracker           = new();
    cycle_count       = 0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_LOAD;
    in_bus.word_index <= '0;
    in_bus.data_hi    <= '0;
    in_bus.data_lo    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats run with neither side idling
    run_directed();

    // random beats spread over the idle/stall phases
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      for (int n = 0; n < RandomBeats / PhaseCount; n++) send_random_beat();
    end
    in_bus.valid <= 1'b0;

    // let the last results drain, then watch a little longer for strays
    sink_stall_pct = 0;
    while (tracker.expected_blocks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    tracker.flush_check();

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/m640_pkg.sv
hw/rtl/m640_in_if.sv
hw/rtl/m640_out_if.sv
hw/rtl/m640_front.sv
hw/rtl/m640_queue.sv
hw/rtl/m640_back.sv
hw/rtl/morus640_encrypt_step.sv
sim/tb.sv
